// ----- hdl/qrv_pkg.sv -----
package qrv_pkg;

    localparam int QW = 16;          // quaternion component width
    localparam int VW = 32;          // vector / result component width
    localparam int NW = 33;          // squared norm width
    localparam int MW = 34;          // rotation matrix entry width
    localparam int PW = MW + VW;     // matrix * vector product width
    localparam int AW = PW + 2;      // row accumulator width
    localparam int DW = NW + 1;      // divisor (2n) width
    localparam int XW = 67;          // rounded numerator 2|acc| + n
    localparam int QB = 32;          // quotient bits resolved in the divider
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = QB / DIV_BITS_PER_STAGE;

    localparam logic [VW-1:0] POS_LIMIT = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] NEG_LIMIT = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
        logic signed [VW-1:0] vec_x;
        logic signed [VW-1:0] vec_y;
        logic signed [VW-1:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0] out_x;
        logic signed [VW-1:0] out_y;
        logic signed [VW-1:0] out_z;
        logic                 degenerate;
        logic                 saturated;
    } t_out;

    // One row of the restoring divider in flight
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QB-1:0] lo;
        logic [QB-1:0] q;
    } t_div_row;

endpackage

// ----- hdl/qrv_if.sv -----
interface qrv_in_if;
    import qrv_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qrv_out_if;
    import qrv_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/quaternion_rotate_vector.sv -----
// Rotates a Q16.16 3-vector by a Q1.14 quaternion of any nonzero length and
// returns the rotated vector as Q16.16, rounded to nearest (ties away from
// zero) and saturated to 32 bits, with a saturated flag. A zero quaternion
// gives a zero vector and the degenerate flag. The quaternion is not
// normalized up front: the exact integer matrix M = n*R is built from the raw
// components, M*v is formed exactly and divided once by the squared norm n.
// Throughput is one transaction per clock while results are taken. The stages
// are squares and cross products, matrix build, matrix-vector products, row
// sums, rounding setup, eight divider stages of four quotient bits each, and
// the output register. The whole pipeline holds while a finished result is
// not taken, so nothing is lost or repeated under backpressure.
module quaternion_rotate_vector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qrv_in_if.sink              i_vec,
    qrv_out_if.source           o_res
);
    import qrv_pkg::*;

    logic adv;

    // stage 1: products of quaternion components
    logic                 r1_valid;
    logic signed [2*QW-1:0] r1_xx, r1_yy, r1_zz, r1_ww;
    logic signed [2*QW-1:0] r1_xy, r1_wz, r1_xz, r1_wy, r1_yz, r1_wx;
    logic signed [VW-1:0] r1_v [3];

    // stage 2: norm and matrix
    logic                 r2_valid;
    logic        [NW-1:0] r2_n;
    logic signed [MW-1:0] r2_m [9];
    logic signed [VW-1:0] r2_v [3];

    // stage 3: matrix * vector products
    logic                 r3_valid;
    logic        [NW-1:0] r3_n;
    logic signed [PW-1:0] r3_p [9];

    // stage 4: row sums
    logic                 r4_valid;
    logic        [NW-1:0] r4_n;
    logic signed [AW-1:0] r4_acc [3];

    // divider pipeline, index 0 is the rounding setup stage
    logic          r_dv    [DIV_STAGES+1];
    logic          r_degen [DIV_STAGES+1];
    logic [DW-1:0] r_d     [DIV_STAGES+1];
    logic [2:0]    r_neg   [DIV_STAGES+1];
    logic [2:0]    r_ovf   [DIV_STAGES+1];
    t_div_row      r_div   [DIV_STAGES+1][3];

    // output register
    logic r_ovalid;
    t_out r_odata;

    assign adv         = !r_ovalid || o_res.ready;
    assign i_vec.ready = adv;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r1_valid <= i_vec.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r_dv[0]  <= r4_valid;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_ovalid <= r_dv[DIV_STAGES];
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_xx <= i_vec.data.quat_x * i_vec.data.quat_x;
            r1_yy <= i_vec.data.quat_y * i_vec.data.quat_y;
            r1_zz <= i_vec.data.quat_z * i_vec.data.quat_z;
            r1_ww <= i_vec.data.quat_w * i_vec.data.quat_w;
            r1_xy <= i_vec.data.quat_x * i_vec.data.quat_y;
            r1_wz <= i_vec.data.quat_w * i_vec.data.quat_z;
            r1_xz <= i_vec.data.quat_x * i_vec.data.quat_z;
            r1_wy <= i_vec.data.quat_w * i_vec.data.quat_y;
            r1_yz <= i_vec.data.quat_y * i_vec.data.quat_z;
            r1_wx <= i_vec.data.quat_w * i_vec.data.quat_x;
            r1_v[0] <= i_vec.data.vec_x;
            r1_v[1] <= i_vec.data.vec_y;
            r1_v[2] <= i_vec.data.vec_z;
        end
    end

    // ---------------- stage 2 ----------------
    logic signed [MW-1:0] n2_m [9];
    logic        [NW-1:0] n2_n;

    always_comb begin
        n2_n = NW'(r1_xx) + NW'(r1_yy) + NW'(r1_zz) + NW'(r1_ww);
        n2_m[0] = MW'(r1_ww) + MW'(r1_xx) - MW'(r1_yy) - MW'(r1_zz);
        n2_m[4] = MW'(r1_ww) - MW'(r1_xx) + MW'(r1_yy) - MW'(r1_zz);
        n2_m[8] = MW'(r1_ww) - MW'(r1_xx) - MW'(r1_yy) + MW'(r1_zz);
        n2_m[1] = (MW'(r1_xy) - MW'(r1_wz)) <<< 1;
        n2_m[2] = (MW'(r1_xz) + MW'(r1_wy)) <<< 1;
        n2_m[3] = (MW'(r1_xy) + MW'(r1_wz)) <<< 1;
        n2_m[5] = (MW'(r1_yz) - MW'(r1_wx)) <<< 1;
        n2_m[6] = (MW'(r1_xz) - MW'(r1_wy)) <<< 1;
        n2_m[7] = (MW'(r1_yz) + MW'(r1_wx)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_n <= n2_n;
            r2_m <= n2_m;
            r2_v <= r1_v;
        end
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_n <= r2_n;
            for (int i = 0; i < 9; i++) begin
                r3_p[i] <= PW'(r2_m[i]) * PW'(r2_v[i % 3]);
            end
        end
    end

    // ---------------- stage 4 ----------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_n <= r3_n;
            for (int r = 0; r < 3; r++) begin
                r4_acc[r] <= AW'(r3_p[3*r]) + AW'(r3_p[3*r+1]) + AW'(r3_p[3*r+2]);
            end
        end
    end

    // ---------------- rounding setup ----------------
    // numerator 2|acc| + n over divisor 2n gives round half away from zero;
    // a quotient of 2^32 or more is flagged as overflow up front
    logic [XW-1:0] n5_num [3];
    logic [AW-1:0] n5_mag [3];
    logic [DW-1:0] n5_d;

    always_comb begin
        n5_d = {r4_n, 1'b0};
        for (int r = 0; r < 3; r++) begin
            n5_mag[r] = r4_acc[r][AW-1] ? AW'(-r4_acc[r]) : AW'(r4_acc[r]);
            n5_num[r] = XW'({n5_mag[r][XW-2:0], 1'b0}) + XW'(r4_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d[0]     <= n5_d;
            r_degen[0] <= (r4_n == '0);
            for (int r = 0; r < 3; r++) begin
                r_neg[0][r]    <= r4_acc[r][AW-1];
                r_ovf[0][r]    <= (n5_num[r][XW-1:QB] >= (XW-QB)'(n5_d));
                r_div[0][r].rem <= (n5_num[r][XW-1:QB] >= (XW-QB)'(n5_d)) ?
                                   '0 : n5_num[r][QB+DW-1:QB];
                r_div[0][r].lo <= n5_num[r][QB-1:0];
                r_div[0][r].q  <= '0;
            end
        end
    end

    // ---------------- divider stages ----------------
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        t_div_row n_row [3];

        always_comb begin
            logic [DW:0] t;
            for (int r = 0; r < 3; r++) begin
                n_row[r] = r_div[k-1][r];
                for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                    t = {n_row[r].rem, n_row[r].lo[QB-1]};
                    n_row[r].lo = {n_row[r].lo[QB-2:0], 1'b0};
                    if (t >= {1'b0, r_d[k-1]}) begin
                        n_row[r].rem = DW'(t - {1'b0, r_d[k-1]});
                        n_row[r].q   = {n_row[r].q[QB-2:0], 1'b1};
                    end else begin
                        n_row[r].rem = t[DW-1:0];
                        n_row[r].q   = {n_row[r].q[QB-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_d[k]     <= r_d[k-1];
                r_degen[k] <= r_degen[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_ovf[k]   <= r_ovf[k-1];
                r_div[k]   <= n_row;
            end
        end
    end

    // ---------------- sign, saturation, output ----------------
    logic [VW-1:0] n_comp [3];
    logic [2:0]    n_sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_neg[DIV_STAGES][r]) begin
                n_sat[r]  = r_ovf[DIV_STAGES][r] || (r_div[DIV_STAGES][r].q > NEG_LIMIT);
                n_comp[r] = n_sat[r] ? NEG_LIMIT : VW'(-r_div[DIV_STAGES][r].q);
            end else begin
                n_sat[r]  = r_ovf[DIV_STAGES][r] || (r_div[DIV_STAGES][r].q > POS_LIMIT);
                n_comp[r] = n_sat[r] ? POS_LIMIT : r_div[DIV_STAGES][r].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_degen[DIV_STAGES]) begin
                r_odata.out_x      <= '0;
                r_odata.out_y      <= '0;
                r_odata.out_z      <= '0;
                r_odata.degenerate <= 1'b1;
                r_odata.saturated  <= 1'b0;
            end else begin
                r_odata.out_x      <= n_comp[0];
                r_odata.out_y      <= n_comp[1];
                r_odata.out_z      <= n_comp[2];
                r_odata.degenerate <= 1'b0;
                r_odata.saturated  <= |n_sat;
            end
        end
    end

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.degenerate |->
            o_res.data.out_x == '0 && o_res.data.out_y == '0 &&
            o_res.data.out_z == '0 && !o_res.data.saturated)
        else $error("degenerate result not zero");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_dv[0]) && $stable(r4_valid) && $stable(r1_valid))
        else $error("pipeline moved during stall");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.saturated |->
            o_res.data.out_x == POS_LIMIT || o_res.data.out_x == NEG_LIMIT ||
            o_res.data.out_y == POS_LIMIT || o_res.data.out_y == NEG_LIMIT ||
            o_res.data.out_z == POS_LIMIT || o_res.data.out_z == NEG_LIMIT)
        else $error("saturated flag without clipped component");
`endif

endmodule
